// ===== hw/rtl/itrgb_pkg.sv =====
package itrgb_pkg;

    // field widths
    localparam int CNT_W  = 16;
    localparam int MODE_W = 3;
    localparam int CH_W   = 8;
    localparam int CLR_W  = 27;
    localparam int IN_TDATA_W  = ((CNT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CLR_W + 7) / 8) * 8;

    // fixed point format of t and u
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

    // divider: quotient bits resolved per register stage
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

    // curve scale factors (255 times 9, 8.5 * 2, 15)
    localparam int K_W = 13;
    localparam logic [K_W-1:0] K_A = K_W'(2295);
    localparam logic [K_W-1:0] K_B = K_W'(4335);
    localparam logic [K_W-1:0] K_C = K_W'(3825);
    localparam int SCL_W = T_W + K_W;

    // palette masks
    localparam logic [CH_W-1:0] DARK_MASK  = CH_W'(8'h15);
    localparam logic [CH_W-1:0] CLOWN_MASK = CH_W'(8'h11);
    localparam int CLOWN_W = 11;
    localparam logic [CLOWN_W-1:0] CLOWN_GAIN = CLOWN_W'(100);

    localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(50);

    // palette modes
    localparam logic [MODE_W-1:0] MODE_DARK  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_BLUE  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_RED   = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_CLOWN = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_GREEN = MODE_W'(4);

    // normalised count handed from divider to curve pipeline
    typedef struct packed {
        logic [T_W-1:0]    t;
        logic [MODE_W-1:0] mode;
    } t_norm;

    // curve values handed to the palette stage
    typedef struct packed {
        logic [CH_W-1:0]   a;
        logic [CH_W-1:0]   b;
        logic [CH_W-1:0]   c;
        logic [MODE_W-1:0] mode;
    } t_curves;

    // Q.F product truncated back to Q.F; operands never exceed one
    function automatic logic [T_W-1:0] fx_mul(input logic [T_W-1:0] x,
                                              input logic [T_W-1:0] y);
        logic [2*T_W-1:0] prod;
        prod = x * y;
        return prod[FRAC_BITS +: T_W];
    endfunction

    // clown channel: keep bits 0 and 4, scale by 100
    function automatic logic [CLOWN_W-1:0] clown_ch(input logic [CH_W-1:0] ch);
        logic [CLOWN_W-1:0] m;
        m = CLOWN_W'(ch & CLOWN_MASK);
        return CLOWN_W'(m * CLOWN_GAIN);
    endfunction

endpackage

// ===== hw/rtl/itrgb_div.sv =====
module itrgb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [itrgb_pkg::CNT_W-1:0]   i_count,
    input  logic [itrgb_pkg::MODE_W-1:0]  i_mode,
    input  logic [itrgb_pkg::CNT_W-1:0]   i_limit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output itrgb_pkg::t_norm              o_norm
);

    localparam int N = itrgb_pkg::DIV_STAGES;

    logic                           r_v    [0:N];
    logic [itrgb_pkg::CNT_W-1:0]    r_rem  [0:N];
    logic [itrgb_pkg::T_W-1:0]      r_quo  [0:N];
    logic [itrgb_pkg::MODE_W-1:0]   r_mode [0:N];
    logic                           w_rdy  [0:N+1];

    logic [itrgb_pkg::CNT_W-1:0]    w_lim;
    logic [itrgb_pkg::CNT_W-1:0]    w_cnt;
    logic                           w_top;

    // a zero limit counts as one
    assign w_lim = (i_limit == '0) ? itrgb_pkg::CNT_W'(1) : i_limit;

    // ready ripples back: a stage takes new data when empty or draining
    assign w_rdy[N+1] = i_ready;
    for (genvar s = 0; s <= N; s++) begin : g_rdy
        assign w_rdy[s] = !r_v[s] || w_rdy[s+1];
    end
    assign o_ready = w_rdy[0];

    // entry stage: clamp, then the integer quotient bit (count == limit)
    assign w_cnt = (i_count > w_lim) ? w_lim : i_count;
    assign w_top = (w_cnt == w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_rem[0]  <= w_top ? '0 : w_cnt;
            r_quo[0]  <= itrgb_pkg::T_W'(w_top);
            r_mode[0] <= i_mode;
        end
    end

    // restoring division, DIV_STEPS fraction bits per stage
    for (genvar s = 1; s <= N; s++) begin : g_stage
        logic [itrgb_pkg::CNT_W-1:0] n_rem;
        logic [itrgb_pkg::T_W-1:0]   n_quo;

        always_comb begin
            logic [itrgb_pkg::CNT_W:0] v_trial;
            n_rem   = r_rem[s-1];
            n_quo   = r_quo[s-1];
            v_trial = '0;
            for (int j = 0; j < itrgb_pkg::DIV_STEPS; j++) begin
                if ((s - 1) * itrgb_pkg::DIV_STEPS + j < itrgb_pkg::FRAC_BITS) begin
                    v_trial = {n_rem, 1'b0};
                    if (v_trial >= {1'b0, w_lim}) begin
                        n_rem = itrgb_pkg::CNT_W'(v_trial - {1'b0, w_lim});
                        n_quo = {n_quo[itrgb_pkg::T_W-2:0], 1'b1};
                    end else begin
                        n_rem = v_trial[itrgb_pkg::CNT_W-1:0];
                        n_quo = {n_quo[itrgb_pkg::T_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_rem[s]  <= n_rem;
                r_quo[s]  <= n_quo;
                r_mode[s] <= r_mode[s-1];
            end
        end
    end

    assign o_valid     = r_v[N];
    assign o_norm.t    = r_quo[N];
    assign o_norm.mode = r_mode[N];

    // partial remainder must stay below the divisor in every live stage
    for (genvar s = 0; s <= N; s++) begin : g_chk
        a_rem_below_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v[s] |-> (r_rem[s] < w_lim))
            else $error("divider remainder not below limit");
    end

    // normalised count never exceeds one
    a_t_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_norm.t <= itrgb_pkg::T_ONE))
        else $error("normalised count above one");

endmodule

// ===== hw/rtl/itrgb_curves.sv =====
module itrgb_curves (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  itrgb_pkg::t_norm   i_norm,
    output logic               o_valid,
    input  logic               i_ready,
    output itrgb_pkg::t_curves o_curves
);

    localparam int TW = itrgb_pkg::T_W;
    localparam int FB = itrgb_pkg::FRAC_BITS;
    localparam int CW = itrgb_pkg::CH_W;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic [TW-1:0] w_u;
    logic [TW-1:0] r_t1, r_u1, r_tt1, r_uu1, r_m1;
    logic [TW-1:0] r_t2, r_u2, r_ttt2, r_uuu2, r_r2;
    logic [TW-1:0] r_p3, r_q3;
    logic [CW-1:0] r_c3;
    itrgb_pkg::t_curves r_out4;
    logic [itrgb_pkg::MODE_W-1:0] r_mode1, r_mode2, r_mode3;

    logic [itrgb_pkg::SCL_W-1:0] n_prod_a, n_prod_b, n_prod_c;

    // stall chain
    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_u = itrgb_pkg::T_ONE - i_norm.t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: t^2, u^2, u*t
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_t1    <= i_norm.t;
            r_u1    <= w_u;
            r_tt1   <= itrgb_pkg::fx_mul(i_norm.t, i_norm.t);
            r_uu1   <= itrgb_pkg::fx_mul(w_u, w_u);
            r_m1    <= itrgb_pkg::fx_mul(w_u, i_norm.t);
            r_mode1 <= i_norm.mode;
        end
    end

    // stage 2: t^3, u^3, (ut)^2
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_t2    <= r_t1;
            r_u2    <= r_u1;
            r_ttt2  <= itrgb_pkg::fx_mul(r_tt1, r_t1);
            r_uuu2  <= itrgb_pkg::fx_mul(r_uu1, r_u1);
            r_r2    <= itrgb_pkg::fx_mul(r_m1, r_m1);
            r_mode2 <= r_mode1;
        end
    end

    // stage 3: u*t^3, u^3*t, scale of the C curve
    assign n_prod_c = r_r2 * itrgb_pkg::K_C;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_p3    <= itrgb_pkg::fx_mul(r_ttt2, r_u2);
            r_q3    <= itrgb_pkg::fx_mul(r_uuu2, r_t2);
            r_c3    <= n_prod_c[FB +: CW];
            r_mode3 <= r_mode2;
        end
    end

    // stage 4: scale of the A and B curves (B carries the half)
    assign n_prod_a = r_p3 * itrgb_pkg::K_A;
    assign n_prod_b = r_q3 * itrgb_pkg::K_B;

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_out4.a    <= n_prod_a[FB +: CW];
            r_out4.b    <= n_prod_b[FB+1 +: CW];
            r_out4.c    <= r_c3;
            r_out4.mode <= r_mode3;
        end
    end

    assign o_valid  = r_v4;
    assign o_curves = r_out4;

    // truncated products stay within one
    a_prod_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_p3 <= itrgb_pkg::T_ONE) && (r_q3 <= itrgb_pkg::T_ONE))
        else $error("curve product above one");

    // scaled A and B curves fit one channel byte, nothing lost by truncation
    a_curve_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ((n_prod_a >> (FB + CW)) == '0) && ((n_prod_b >> (FB + 1 + CW)) == '0))
        else $error("curve value exceeds channel width");

endmodule

// ===== hw/rtl/itrgb_map.sv =====
module itrgb_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  itrgb_pkg::t_curves          i_curves,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [itrgb_pkg::CLR_W-1:0] o_color
);

    localparam int CW = itrgb_pkg::CH_W;
    localparam int KW = itrgb_pkg::CLOWN_W;
    localparam int OW = itrgb_pkg::CLR_W;

    logic          r_v;
    logic [OW-1:0] r_color;
    logic          w_load;
    logic [KW-1:0] n_red, n_green, n_blue;
    logic [OW-1:0] n_color;

    assign w_load  = !r_v || i_ready;
    assign o_ready = w_load;

    // route curves to channels per palette
    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        unique case (i_curves.mode)
            itrgb_pkg::MODE_DARK: begin
                n_red   = KW'(i_curves.a);
                n_green = KW'(i_curves.b & itrgb_pkg::DARK_MASK);
                n_blue  = KW'(i_curves.c);
            end
            itrgb_pkg::MODE_BLUE: begin
                n_red   = KW'(i_curves.c);
                n_green = KW'(i_curves.a);
                n_blue  = KW'(i_curves.b);
            end
            itrgb_pkg::MODE_RED: begin
                n_red   = KW'(i_curves.b);
                n_green = KW'(i_curves.c);
                n_blue  = KW'(i_curves.a);
            end
            itrgb_pkg::MODE_CLOWN: begin
                n_red   = itrgb_pkg::clown_ch(i_curves.b);
                n_green = itrgb_pkg::clown_ch(i_curves.c);
                n_blue  = itrgb_pkg::clown_ch(i_curves.a);
            end
            itrgb_pkg::MODE_GREEN: begin
                n_red   = KW'(i_curves.c);
                n_green = KW'(i_curves.b);
                n_blue  = KW'(i_curves.a);
            end
            default: begin
                n_red   = '0;
                n_green = '0;
                n_blue  = '0;
            end
        endcase
    end

    // pack, overlapping clown bits OR together
    assign n_color = (OW'(n_red) << (2 * CW)) | (OW'(n_green) << CW) | OW'(n_blue);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_load) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_color <= n_color;
        end
    end

    assign o_valid = r_v;
    assign o_color = r_color;

    // undefined palette gives black
    a_undef_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && i_valid && (i_curves.mode > itrgb_pkg::MODE_GREEN)) |=> (r_color == '0))
        else $error("undefined palette produced colour");

endmodule

// ===== hw/rtl/iteration_to_rgb_palette.sv =====
// Iteration count to RGB palette.
// Input stream: one transfer per pixel; tdata holds the escape iteration
// count, tuser the palette (dark, blue, red, clown, green; other codes
// give black). Output stream: one transfer per pixel with the packed
// colour red<<16 | green<<8 | blue, overlapping bits ORed.
// The iteration limit is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while no pixel is in flight (the block does not enforce
// this). A limit of zero behaves as one. Path from input transfer to
// output valid: clamp stage, 8 divider stages resolving 2 quotient bits
// each, 4 multiplier stages, palette/output register. Throughput: one pixel
// per cycle without output stalls, set by the fully pipelined divider and
// multiplier chains. Every stage holds its data when the next one is full,
// so a stall at the output fills the empty stages first and then deasserts
// tready; nothing is lost or repeated.
// Reset clears all valid bits and sets the limit to 50.
module iteration_to_rgb_palette (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [15:0] iteration_count
    input  logic [itrgb_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [2:0] mode
    input  logic [itrgb_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [26:0] color, [31:27] zero
    output logic [itrgb_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [itrgb_pkg::CNT_W-1:0]       i_cfg_wdata
);

    logic [itrgb_pkg::CNT_W-1:0] r_max_iter;

    logic               w_div_valid, w_div_ready;
    itrgb_pkg::t_norm   w_norm;
    logic               w_crv_valid, w_crv_ready;
    itrgb_pkg::t_curves w_curves;
    logic [itrgb_pkg::CLR_W-1:0] w_color;

    // iteration limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= itrgb_pkg::MAX_ITER_RST;
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_wdata;
        end
    end

    itrgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_count (i_s_axis_tdata[itrgb_pkg::CNT_W-1:0]),
        .i_mode  (i_s_axis_tuser),
        .i_limit (r_max_iter),
        .o_valid (w_div_valid),
        .i_ready (w_div_ready),
        .o_norm  (w_norm)
    );

    itrgb_curves u_curves (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_div_valid),
        .o_ready  (w_div_ready),
        .i_norm   (w_norm),
        .o_valid  (w_crv_valid),
        .i_ready  (w_crv_ready),
        .o_curves (w_curves)
    );

    itrgb_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_crv_valid),
        .o_ready  (w_crv_ready),
        .i_curves (w_curves),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_color  (w_color)
    );

    assign o_m_axis_tdata = itrgb_pkg::OUT_TDATA_W'(w_color);

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 30;
    localparam int PHASE_ITEMS = 90;

    typedef struct {
        logic [itrgb_pkg::CNT_W-1:0]  count;
        logic [itrgb_pkg::MODE_W-1:0] mode;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [itrgb_pkg::IN_TDATA_W-1:0] in_data = '0;
    logic [itrgb_pkg::MODE_W-1:0] in_mode = '0;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [itrgb_pkg::CNT_W-1:0] cfg_wdata = '0;
    logic s_ready;
    logic out_valid;
    logic [itrgb_pkg::OUT_TDATA_W-1:0] out_data;

    t_pixel pixel_q[$];
    logic [itrgb_pkg::CLR_W-1:0] expected_colors[$];
    logic [itrgb_pkg::CNT_W-1:0] cur_limit = itrgb_pkg::MAX_ITER_RST;
    bit no_idle = 1'b0;
    int mismatches = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int idle_cycles = 0;

    iteration_to_rgb_palette i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_mode),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // expected colour of one pixel under the given limit
    function automatic logic [itrgb_pkg::CLR_W-1:0] palette_color(
        input logic [itrgb_pkg::CNT_W-1:0]  count,
        input logic [itrgb_pkg::MODE_W-1:0] mode,
        input logic [itrgb_pkg::CNT_W-1:0]  limit);
        logic [63:0] lim, it, t, u, p, q, m, r, a, b, c, red, green, blue;
        lim = (limit == 0) ? 64'd1 : 64'(limit);
        it = (64'(count) > lim) ? lim : 64'(count);
        t = (it << itrgb_pkg::FRAC_BITS) / lim;
        u = (64'd1 << itrgb_pkg::FRAC_BITS) - t;
        // t^3 * u
        p = (t * t) >> itrgb_pkg::FRAC_BITS;
        p = (p * t) >> itrgb_pkg::FRAC_BITS;
        p = (p * u) >> itrgb_pkg::FRAC_BITS;
        a = (64'(itrgb_pkg::K_A) * p) >> itrgb_pkg::FRAC_BITS;
        // u^3 * t, factor carries one extra bit for the half
        q = (u * u) >> itrgb_pkg::FRAC_BITS;
        q = (q * u) >> itrgb_pkg::FRAC_BITS;
        q = (q * t) >> itrgb_pkg::FRAC_BITS;
        b = (64'(itrgb_pkg::K_B) * q) >> (itrgb_pkg::FRAC_BITS + 1);
        // (u * t)^2
        m = (u * t) >> itrgb_pkg::FRAC_BITS;
        r = (m * m) >> itrgb_pkg::FRAC_BITS;
        c = (64'(itrgb_pkg::K_C) * r) >> itrgb_pkg::FRAC_BITS;
        red = 0;
        green = 0;
        blue = 0;
        case (mode)
            itrgb_pkg::MODE_DARK: begin
                red = a;
                green = b & 64'(itrgb_pkg::DARK_MASK);
                blue = c;
            end
            itrgb_pkg::MODE_BLUE: begin
                red = c;
                green = a;
                blue = b;
            end
            itrgb_pkg::MODE_RED: begin
                red = b;
                green = c;
                blue = a;
            end
            itrgb_pkg::MODE_CLOWN: begin
                red = (b & 64'(itrgb_pkg::CLOWN_MASK)) * 64'(itrgb_pkg::CLOWN_GAIN);
                green = (c & 64'(itrgb_pkg::CLOWN_MASK)) * 64'(itrgb_pkg::CLOWN_GAIN);
                blue = (a & 64'(itrgb_pkg::CLOWN_MASK)) * 64'(itrgb_pkg::CLOWN_GAIN);
            end
            itrgb_pkg::MODE_GREEN: begin
                red = c;
                green = b;
                blue = a;
            end
            default: ; // unused codes give black
        endcase
        return itrgb_pkg::CLR_W'((red << 16) | (green << 8) | blue);
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // source: present queued pixels, record the expected colour on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && s_ready)
                expected_colors.push_back(
                    palette_color(in_data[itrgb_pkg::CNT_W-1:0], in_mode, cur_limit));
            if (!in_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= itrgb_pkg::IN_TDATA_W'(pixel_q[0].count);
                    in_mode <= pixel_q[0].mode;
                    void'(pixel_q.pop_front());
                    src_gap = pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // sink: check each colour transfer, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_colors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected colour transfer: got %h",
                                 out_data[itrgb_pkg::CLR_W-1:0]);
                end else begin
                    if (out_data[itrgb_pkg::CLR_W-1:0] !== expected_colors[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("colour mismatch: expected %h got %h",
                                     expected_colors[0], out_data[itrgb_pkg::CLR_W-1:0]);
                    end
                    void'(expected_colors.pop_front());
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                out_ready <= 1'b0;
            end else begin
                sink_gap = pick_gap();
                out_ready <= (sink_gap == 0);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && s_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixel_q.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [itrgb_pkg::CNT_W-1:0] value);
        wait_idle();
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_limit = value;
    endtask

    task automatic add_pixel(input int count, input int mode);
        t_pixel px;
        px.count = itrgb_pkg::CNT_W'(count);
        px.mode = itrgb_pkg::MODE_W'(mode);
        pixel_q.push_back(px);
    endtask

    // random pixels around the current limit; count edges, clamping and noise
    task automatic add_random_pixels(input int n);
        int lim, count, mode, roll;
        lim = (cur_limit == 0) ? 1 : int'(cur_limit);
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                case ($urandom_range(0, 5))
                    0: count = 0;
                    1: count = 1;
                    2: count = lim - 1;
                    3: count = lim;
                    4: count = (lim < 65535) ? lim + 1 : lim;
                    default: count = 65535;
                endcase
            end else if (roll < 60) begin
                count = $urandom_range(0, lim);
            end else begin
                count = $urandom_range(0, 65535);
            end
            if ($urandom_range(0, 9) == 0)
                mode = $urandom_range(0, (1 << itrgb_pkg::MODE_W) - 1);
            else
                mode = $urandom_range(int'(itrgb_pkg::MODE_DARK),
                                      int'(itrgb_pkg::MODE_GREEN));
            add_pixel(count, mode);
        end
    endtask

    initial begin
        int limits[$];
        limits = '{1, 0, 2, 3, 7, 50, 255, 1000, 40000, 65534, 65535};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit, every mode code at zero, mid and full scale
        for (int md = 0; md < (1 << itrgb_pkg::MODE_W); md++) begin
            add_pixel(0, md);
            add_pixel(37, md);
            add_pixel(int'(itrgb_pkg::MAX_ITER_RST), md);
        end
        add_pixel(65535, int'(itrgb_pkg::MODE_DARK));

        // one phase per limit setting, the last one random
        limits.push_back($urandom_range(1, 65535));
        for (int ph = 0; ph < limits.size(); ph++) begin
            write_limit(itrgb_pkg::CNT_W'(limits[ph]));
            no_idle = (ph % 4 == 2);
            add_random_pixels(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0 && expected_colors.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== iteration_to_rgb_palette.f =====
hw/rtl/itrgb_pkg.sv
hw/rtl/itrgb_div.sv
hw/rtl/itrgb_curves.sv
hw/rtl/itrgb_map.sv
hw/rtl/iteration_to_rgb_palette.sv
tb/sv/tb_top.sv
